// ===== hdl/mcps_pkg.sv =====
// Shared constants, command codes and status type for the min-cut partition search.
`default_nettype none
package mcps_pkg;
  localparam int MAX_NODES = 16;
  localparam int COST_BITS = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int CFG_W     = 5;
  localparam int SUM_W     = 16;

  localparam logic IN_LOAD  = 1'b0;
  localparam logic IN_START = 1'b1;

  localparam logic CFG_NODES = 1'b0;
  localparam logic CFG_PARTS = 1'b1;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_NOFIND,
    DP_INIT,
    DP_DESCEND,
    DP_EVAL_START,
    DP_EVAL_STEP,
    DP_COMMIT,
    DP_RETURN,
    DP_EMIT_START,
    DP_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic leaf;
    logic root;
    logic ret_up;
    logic eval_last;
    logic emit_last;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== hdl/mcps_datapath.sv =====
// Datapath: cost memory, label stack, cut-cost accumulator, best tracking and result registers.
`default_nettype none
module mcps_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mcps_pkg::dp_cmd_t         cmd,
  output mcps_pkg::dp_stat_t             stat,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [mcps_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic [mcps_pkg::NODE_W-1:0] in_row,
  input  wire logic [mcps_pkg::NODE_W-1:0] in_col,
  input  wire logic [7:0]                in_cost_value,
  output logic                           out_valid,
  output logic [3:0]                     out_node_index,
  output logic [3:0]                     out_block_label,
  output logic [15:0]                    out_best_cost,
  output logic                           out_found,
  output logic                           out_last
);
  import mcps_pkg::*;

  logic [CFG_W-1:0]     nodes_r, parts_r;
  logic [CFG_W-1:0]     eff;
  logic [CFG_W-1:0]     n_r, k_r, n_dec, eff_m1;
  logic [CNT_W-1:0]     cnt_r [MAX_NODES];
  logic [CNT_W-1:0]     kk_r  [MAX_NODES];
  logic [NODE_W-1:0]    lbl_r [MAX_NODES];
  logic [NODE_W-1:0]    best_lbl_r [MAX_NODES];
  logic [SUM_W-1:0]     best_r;
  logic                 best_vld_r;
  logic [NODE_W-1:0]    r_r, c_r, idx_r;
  logic [SUM_W:0]       acc_r;
  logic [COST_BITS-1:0] mem [MAX_NODES*MAX_NODES];
  logic [COST_BITS-1:0] rdata_r;
  logic                 pv_r, df_r;
  logic [NODE_W-1:0]    p, pd, row_lbl;
  logic [CNT_W-1:0]     cnt_inc, kk_p;
  logic                 br_next, br_open;
  logic [MAX_NODES-1:0] eq_v;
  logic [SUM_W-1:0]     cost;

  assign eff     = (nodes_r > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : nodes_r;
  assign eff_m1  = eff - CFG_W'(1);
  assign n_dec   = n_r - CFG_W'(1);
  assign p       = n_r[NODE_W-1:0];
  assign pd      = n_dec[NODE_W-1:0];
  assign cnt_inc = cnt_r[p] + CNT_W'(1);
  assign kk_p    = kk_r[p];
  assign br_next = cnt_inc < kk_p;
  assign br_open = (cnt_inc == kk_p) && (kk_p > CNT_W'(1));
  assign row_lbl = lbl_r[r_r];
  assign cost    = acc_r[SUM_W] ? '1 : acc_r[SUM_W-1:0];

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      eq_v[j] = (lbl_r[j] == row_lbl);
    end
  end

  always_comb begin
    stat.bad       = (parts_r == '0) || (parts_r > eff);
    stat.leaf      = (n_r == k_r);
    stat.root      = (n_r == eff);
    stat.ret_up    = !(br_next || br_open);
    stat.eval_last = ({1'b0, r_r} == eff_m1) && ({1'b0, c_r} == eff_m1);
    stat.emit_last = ({1'b0, idx_r} == eff_m1);
  end

  // cost memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD) begin
      mem[{in_row, in_col}] <= in_cost_value[COST_BITS-1:0];
    end
    rdata_r <= mem[{r_r, c_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r    <= CFG_W'(4);
      parts_r    <= CFG_W'(2);
      best_r     <= '1;
      best_vld_r <= 1'b0;
      pv_r       <= 1'b0;
      out_valid  <= 1'b0;
      n_r        <= '0;
      k_r        <= '0;
      for (int j = 0; j < MAX_NODES; j++) begin
        cnt_r[j] <= '0;
        kk_r[j]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODES) nodes_r <= cfg_wdata;
        else parts_r <= cfg_wdata;
      end
      pv_r      <= (cmd == DP_EVAL_STEP);
      out_valid <= (cmd == DP_EMIT) || (cmd == DP_NOFIND);
      if (pv_r && df_r) begin
        acc_r <= acc_r + (SUM_W+1)'(rdata_r);
      end
      case (cmd)
        DP_INIT: begin
          n_r        <= eff;
          k_r        <= parts_r;
          best_r     <= '1;
          best_vld_r <= 1'b0;
          for (int j = 0; j < MAX_NODES; j++) begin
            lbl_r[j] <= NODE_W'(j);
          end
        end
        DP_DESCEND: begin
          cnt_r[pd] <= '0;
          kk_r[pd]  <= k_r;
          lbl_r[pd] <= '0;
          n_r       <= n_dec;
        end
        DP_EVAL_START: begin
          r_r   <= '0;
          c_r   <= '0;
          acc_r <= '0;
        end
        DP_EVAL_STEP: begin
          df_r <= !eq_v[c_r];
          if ({1'b0, c_r} == eff_m1) begin
            c_r <= '0;
            r_r <= r_r + NODE_W'(1);
          end else begin
            c_r <= c_r + NODE_W'(1);
          end
        end
        DP_COMMIT: begin
          if (!best_vld_r || cost < best_r) begin
            best_vld_r <= 1'b1;
            best_r     <= cost;
            for (int j = 0; j < MAX_NODES; j++) begin
              best_lbl_r[j] <= lbl_r[j];
            end
          end
        end
        DP_RETURN: begin
          if (br_next) begin
            cnt_r[p] <= cnt_inc;
            lbl_r[p] <= cnt_inc[NODE_W-1:0];
            k_r      <= kk_p;
          end else if (br_open) begin
            cnt_r[p] <= cnt_inc;
            lbl_r[p] <= kk_p[NODE_W-1:0] - NODE_W'(1);
            k_r      <= kk_p - CNT_W'(1);
          end else begin
            lbl_r[p] <= p;
            n_r      <= n_r + CFG_W'(1);
            k_r      <= kk_p;
          end
        end
        DP_EMIT_START: idx_r <= '0;
        DP_EMIT: begin
          out_node_index  <= idx_r;
          out_block_label <= best_lbl_r[idx_r];
          out_best_cost   <= best_r;
          out_found       <= 1'b1;
          out_last        <= stat.emit_last;
          idx_r           <= idx_r + NODE_W'(1);
        end
        DP_NOFIND: begin
          out_node_index  <= '0;
          out_block_label <= '0;
          out_best_cost   <= '1;
          out_found       <= 1'b0;
          out_last        <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mcps_ctrl.sv =====
// Controller: sequences loads, the enumeration walk, cut-cost sweeps and result emission.
`default_nettype none
module mcps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               in_cmd,
  input  wire mcps_pkg::dp_stat_t stat,
  output mcps_pkg::dp_cmd_t       cmd,
  output logic                    busy
);
  import mcps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_EVAL, S_DRAIN, S_CMP, S_RET, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = DP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == IN_LOAD) begin
            cmd = DP_LOAD;
          end else if (stat.bad) begin
            cmd = DP_NOFIND;
          end else begin
            cmd       = DP_INIT;
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (stat.leaf) begin
          cmd       = DP_EVAL_START;
          state_nxt = S_EVAL;
        end else begin
          cmd = DP_DESCEND;
        end
      end
      S_EVAL: begin
        cmd = DP_EVAL_STEP;
        if (stat.eval_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_CMP;
      S_CMP: begin
        cmd       = DP_COMMIT;
        state_nxt = S_RET;
      end
      S_RET: begin
        if (stat.root) begin
          cmd       = DP_EMIT_START;
          state_nxt = S_EMIT;
        end else begin
          cmd = DP_RETURN;
          if (!stat.ret_up) state_nxt = S_STEP;
        end
      end
      S_EMIT: begin
        cmd = DP_EMIT;
        if (stat.emit_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy    <= (state_nxt != S_IDLE);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/min_cut_partition_search.sv =====
// Top level of the exhaustive k-way min-cut partition search.
//
// Usage: an item is taken when start is high and busy is low. With in_cmd low
// the item writes one cost entry (in_row, in_col, in_cost_value) and gives
// no result; busy stays low, so loads can stream one per cycle.
// With in_cmd high the item starts a search over node_count nodes into exactly
// part_count non-empty parts, set beforehand on the cfg port (index 0 nodes,
// index 1 parts).
// A search walks the labelling tree one step a cycle. Every complete labelling
// is costed by sweeping the n*n cost memory one entry a cycle through its
// single read port, then a drain state and a compare state fold the last read
// into the cut and keep the best. After the walk come n results, one per node.
// Results come one per cycle on out_valid with node, label, best cost,
// out_found and out_last; the receiver cannot stall them.
// When part_count is zero or above the node count, one flagged result appears
// in the cycle after the start item and busy never rises.
// Reset restores the registers to 4 nodes and 2 parts and idles the block;
// the cost memory is not cleared and must be loaded before use.
`default_nettype none
module min_cut_partition_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [3:0]  in_row,
  input  wire logic [3:0]  in_col,
  input  wire logic [7:0]  in_cost_value,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_wdata,
  output logic             out_valid,
  output logic [3:0]       out_node_index,
  output logic [3:0]       out_block_label,
  output logic [15:0]      out_best_cost,
  output logic             out_found,
  output logic             out_last
);
  import mcps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence the walk
  mcps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // hold costs, labels and the best partition
  mcps_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_cost_value   (in_cost_value),
    .out_valid       (out_valid),
    .out_node_index  (out_node_index),
    .out_block_label (out_block_label),
    .out_best_cost   (out_best_cost),
    .out_found       (out_found),
    .out_last        (out_last)
  );

  // a not-found result is always the only one of its run
  a_nofind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("not-found result without last");

  // a load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_cmd == IN_LOAD) |=> !out_valid)
    else $error("result after a load");
endmodule
`default_nettype wire

// ===== tb/sv/min_cut_partition_search_tb.sv =====
// Self-checking testbench for the exhaustive k-way min-cut partition search.
`default_nettype none
module min_cut_partition_search_tb;
  import mcps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT = 2_000_000;
  localparam int RAND_ITEMS = 230;

  typedef struct {
    logic [3:0]  node;
    logic [3:0]  label;
    logic [15:0] cost;
    logic        found;
    logic        last;
  } part_result_t;

  // How a directed row is checked: by the partition predictor, as the
  // flagged no-partition result, or as the trivial single-part answer.
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NO_PART, CHK_ONE_PART} chk_t;
  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_START} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic       idx;
    logic [4:0] data;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] cost;
    chk_t       chk;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_cmd = IN_LOAD;
  logic [3:0] in_row = '0;
  logic [3:0] in_col = '0;
  logic [7:0] in_cost_value = '0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_NODES;
  logic [4:0] cfg_wdata = '0;
  logic       out_valid;
  logic [3:0] out_node_index;
  logic [3:0] out_block_label;
  logic [15:0] out_best_cost;
  logic       out_found;
  logic       out_last;

  min_cut_partition_search dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_row(in_row), .in_col(in_col), .in_cost_value(in_cost_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_node_index(out_node_index),
    .out_block_label(out_block_label), .out_best_cost(out_best_cost),
    .out_found(out_found), .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: its own copy of the cost matrix and the registers.
  logic [7:0] cost_mat [16][16];
  logic [4:0] node_reg = 5'd4;
  logic [4:0] part_reg = 5'd2;
  int         walk_nodes;
  int         trial_lbl [16];
  int         best_lbl [16];
  int         best_cut;
  bit         best_seen;

  part_result_t expected_parts[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;

  task automatic report(input string what);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic int cut_of_trial();
    int sum;
    sum = 0;
    for (int r = 0; r < walk_nodes; r++)
      for (int c = 0; c < walk_nodes; c++)
        if (trial_lbl[r] != trial_lbl[c]) sum += cost_mat[r][c];
    return (sum > 65535) ? 65535 : sum;
  endfunction

  // Walk the labelling tree: the top unplaced node takes labels 0..k-1 with k
  // parts kept, then opens part k-1 with one part fewer left.
  function automatic void walk_labels(input int n, input int k);
    int cut;
    if (n == k) begin
      cut = cut_of_trial();
      if (!best_seen || cut < best_cut) begin
        best_seen = 1'b1;
        best_cut = cut;
        best_lbl = trial_lbl;
      end
      return;
    end
    for (int i = 0; i < k; i++) begin
      trial_lbl[n-1] = i;
      walk_labels(n - 1, k);
    end
    trial_lbl[n-1] = n - 1;
    if (k > 1) begin
      trial_lbl[n-1] = k - 1;
      walk_labels(n - 1, k - 1);
      trial_lbl[n-1] = n - 1;
    end
  endfunction

  function automatic void push_no_part();
    part_result_t e;
    e = '{node: 4'd0, label: 4'd0, cost: 16'hFFFF, found: 1'b0, last: 1'b1};
    expected_parts.push_back(e);
  endfunction

  function automatic int eff_nodes();
    return (node_reg > 16) ? 16 : int'(node_reg);
  endfunction

  function automatic void predict_partition();
    part_result_t e;
    walk_nodes = eff_nodes();
    if (part_reg == 0 || part_reg > walk_nodes) begin
      push_no_part();
      return;
    end
    for (int i = 0; i < 16; i++) trial_lbl[i] = i;
    best_seen = 1'b0;
    best_cut = 65535;
    walk_labels(walk_nodes, part_reg);
    for (int i = 0; i < walk_nodes; i++) begin
      e.node = i[3:0];
      e.label = best_lbl[i][3:0];
      e.cost = best_cut[15:0];
      e.found = 1'b1;
      e.last = (i + 1 == walk_nodes);
      expected_parts.push_back(e);
    end
  endfunction

  // Hand one item over; hold it until busy is low at a rising edge.
  task automatic issue(input logic cmd, input logic [3:0] r, input logic [3:0] c,
                       input logic [7:0] v, input bit predict);
    in_cmd <= cmd;
    in_row <= r;
    in_col <= c;
    in_cost_value <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (cmd == IN_LOAD) cost_mat[r][c] = v;
    else if (predict) predict_partition();
    if (idle_on && $urandom_range(99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain all pending results, then let a search that gives nothing settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_parts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    drain();
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NODES) node_reg = val;
    else part_reg = val;
  endtask

  // Compare every strobed result with the oldest expectation.
  always @(posedge clk) begin
    part_result_t e;
    if (rst_n && out_valid) begin
      if (expected_parts.size() == 0) begin
        report($sformatf("unexpected result node %0d", out_node_index));
      end else begin
        e = expected_parts.pop_front();
        if (out_node_index !== e.node)
          report($sformatf("node %0d, want %0d", out_node_index, e.node));
        if (out_block_label !== e.label)
          report($sformatf("node %0d label %0d, want %0d", e.node, out_block_label, e.label));
        if (out_best_cost !== e.cost)
          report($sformatf("node %0d cost %0d, want %0d", e.node, out_best_cost, e.cost));
        if (out_found !== e.found)
          report($sformatf("node %0d found %0b, want %0b", e.node, out_found, e.found));
        if (out_last !== e.last)
          report($sformatf("node %0d last %0b, want %0b", e.node, out_last, e.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  dir_row_t dir_rows [$] = '{
    // defaults after reset: four nodes, two parts
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_LOAD, CFG_NODES, 5'd0, 4'd0, 4'd1, 8'd255, CHK_PREDICT},
    '{ROW_LOAD, CFG_NODES, 5'd0, 4'd15, 4'd15, 8'd0, CHK_PREDICT},
    '{ROW_LOAD, CFG_NODES, 5'd0, 4'd3, 4'd2, 8'hAA, CHK_PREDICT},
    '{ROW_LOAD, CFG_NODES, 5'd0, 4'd5, 4'd10, 8'h55, CHK_PREDICT},
    // zero nodes: no partition
    '{ROW_CFG, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_NO_PART},
    // zero parts
    '{ROW_CFG, CFG_NODES, 5'd5, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_CFG, CFG_PARTS, 5'd0, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_NO_PART},
    // more parts than nodes
    '{ROW_CFG, CFG_PARTS, 5'd6, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_NO_PART},
    // one part: everything in part 0 at zero cost
    '{ROW_CFG, CFG_PARTS, 5'd1, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_ONE_PART},
    '{ROW_CFG, CFG_NODES, 5'd1, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_ONE_PART},
    '{ROW_CFG, CFG_NODES, 5'd16, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_ONE_PART},
    // node count above sixteen saturates
    '{ROW_CFG, CFG_NODES, 5'd31, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_CFG, CFG_PARTS, 5'd16, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_CFG, CFG_PARTS, 5'd31, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_NO_PART},
    '{ROW_CFG, CFG_PARTS, 5'd15, 4'd0, 4'd0, 8'd0, CHK_PREDICT},
    '{ROW_START, CFG_NODES, 5'd0, 4'd0, 4'd0, 8'd0, CHK_PREDICT}
  };

  initial begin
    dir_row_t   d;
    part_result_t e;
    int         n;
    int         k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole matrix first so that no search reads an unwritten entry.
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        issue(IN_LOAD, r[3:0], c[3:0],
              ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(255)), 1'b0);

    // Directed table.
    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      case (d.kind)
        ROW_CFG: begin
          write_reg(d.idx, d.data);
        end
        ROW_LOAD: begin
          issue(IN_LOAD, d.row, d.col, d.cost, 1'b0);
        end
        default: begin
          issue(IN_START, 4'd0, 4'd0, 8'd0, d.chk == CHK_PREDICT);
          if (d.chk == CHK_NO_PART) begin
            push_no_part();
          end else if (d.chk == CHK_ONE_PART) begin
            n = eff_nodes();
            for (int j = 0; j < n; j++) begin
              e = '{node: j[3:0], label: 4'd0, cost: 16'd0, found: 1'b1, last: j == n - 1};
              expected_parts.push_back(e);
            end
          end
        end
      endcase
    end

    // Random sequences: optional reconfigure, a few loads, then a search.
    // Mostly small sizes; now and then the largest or out-of-range ones.
    for (int items = 0; items < RAND_ITEMS;) begin
      idle_on = !(items >= 90 && items < 150);
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: begin
            n = $urandom_range(16, 31);
            k = ($urandom_range(1) == 0) ? 1 : $urandom_range(16, 31);
          end
          1: begin
            n = 0;
            k = $urandom_range(31);
          end
          default: begin
            n = $urandom_range(1, 6);
            k = $urandom_range(0, n + 1);
          end
        endcase
        write_reg(CFG_NODES, n[4:0]);
        write_reg(CFG_PARTS, k[4:0]);
      end
      repeat ($urandom_range(0, 5)) begin
        issue(IN_LOAD, 4'($urandom_range(15)), 4'($urandom_range(15)),
              8'($urandom_range(255)), 1'b0);
        items++;
      end
      issue(IN_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
            8'($urandom_range(255)), 1'b1);
      items++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_parts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (expected_parts.size() != 0)
        report($sformatf("%0d results never arrived", expected_parts.size()));
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
